// ----- rtl/rbv_pkg.sv -----
// rbv_pkg: shared types and constants for the two-vector rotation block
// no dependencies; imported by every module of the block

package rbv_pkg;

    // field widths
    localparam int unsigned IN_W       = 16;
    localparam int unsigned ROOT_W     = 32;

    // pipelined unit depths
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned UDIV_STEPS = 31;
    localparam int unsigned QDIV_STEPS = 34;

    // one in Q2.14
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    // degenerate case codes
    typedef enum logic [1:0] {
        DEG_NONE = 2'd0,
        DEG_ZERO = 2'd1,
        DEG_PAR  = 2'd2
    } deg_t;

endpackage

// ----- rtl/rbv_sqrt_pipe.sv -----
// rbv_sqrt_pipe: pipelined integer square root of s * 2^32, one root bit per stage
// depends on rbv_pkg

module rbv_sqrt_pipe #(
    parameter int unsigned SW = 1
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rbv_pkg::ROOT_W-1:0] s_in,
    input  logic [SW-1:0]              side_in,
    output logic [rbv_pkg::ROOT_W-1:0] root_out,
    output logic [SW-1:0]              side_out
);
    import rbv_pkg::*;

    localparam int unsigned NS = SQRT_STEPS;

    logic [ROOT_W+1:0] rem_q  [NS];
    logic [ROOT_W-1:0] root_q [NS];
    logic [ROOT_W-1:0] s_q    [NS];
    logic [SW-1:0]     side_q [NS];

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [ROOT_W+1:0] rem_p;
        logic [ROOT_W-1:0] root_p;
        logic [ROOT_W-1:0] s_p;
        logic [SW-1:0]     side_p;
        logic [ROOT_W+3:0] t;
        logic [ROOT_W+3:0] trial;
        logic [ROOT_W+1:0] rem_n;
        logic [ROOT_W-1:0] root_n;

        // previous stage or the input
        if (k == 0) begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign s_p    = s_in;
            assign side_p = side_in;
        end
        else begin : g_next
            assign rem_p  = rem_q[k-1];
            assign root_p = root_q[k-1];
            assign s_p    = s_q[k-1];
            assign side_p = side_q[k-1];
        end

        // bring down two radicand bits, try root*4+1
        always_comb
        begin
            t     = {rem_p, s_p[ROOT_W-1:ROOT_W-2]};
            trial = {2'b00, root_p, 2'b01};
            if (t >= trial)
            begin
                rem_n  = (ROOT_W+2)'(t - trial);
                root_n = {root_p[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_n  = t[ROOT_W+1:0];
                root_n = {root_p[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_q[k]  <= rem_n;
                root_q[k] <= root_n;
                s_q[k]    <= {s_p[ROOT_W-3:0], 2'b00};
                side_q[k] <= side_p;
            end
        end
    end

    assign root_out = root_q[NS-1];
    assign side_out = side_q[NS-1];

endmodule

// ----- rtl/rbv_div_pipe.sv -----
// rbv_div_pipe: pipelined restoring divider, one quotient bit per stage
// depends on rbv_pkg; rem_in must be below dvs_in for a meaningful quotient

module rbv_div_pipe #(
    parameter int unsigned NB = 8,
    parameter int unsigned RW = 8,
    parameter int unsigned SW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] rem_in,
    input  logic [NB-1:0] low_in,
    input  logic [RW-1:0] dvs_in,
    input  logic [SW-1:0] side_in,
    output logic [NB-1:0] quo_out,
    output logic [SW-1:0] side_out
);
    import rbv_pkg::*;

    logic [RW-1:0] rem_q  [NB];
    logic [NB-1:0] low_q  [NB];
    logic [RW-1:0] dvs_q  [NB];
    logic [NB-1:0] quo_q  [NB];
    logic [SW-1:0] side_q [NB];

    for (genvar k = 0; k < NB; k++) begin : g_step
        logic [RW-1:0] rem_p;
        logic [NB-1:0] low_p;
        logic [RW-1:0] dvs_p;
        logic [NB-1:0] quo_p;
        logic [SW-1:0] side_p;
        logic [RW:0]   t;
        logic [RW-1:0] rem_n;
        logic          qb;

        if (k == 0) begin : g_first
            assign rem_p  = rem_in;
            assign low_p  = low_in;
            assign dvs_p  = dvs_in;
            assign quo_p  = '0;
            assign side_p = side_in;
        end
        else begin : g_next
            assign rem_p  = rem_q[k-1];
            assign low_p  = low_q[k-1];
            assign dvs_p  = dvs_q[k-1];
            assign quo_p  = quo_q[k-1];
            assign side_p = side_q[k-1];
        end

        // shift in next dividend bit, subtract divisor when it fits
        always_comb
        begin
            t = {rem_p, low_p[NB-1]};
            if (t >= {1'b0, dvs_p})
            begin
                rem_n = RW'(t - {1'b0, dvs_p});
                qb    = 1'b1;
            end
            else
            begin
                rem_n = t[RW-1:0];
                qb    = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_q[k]  <= rem_n;
                low_q[k]  <= {low_p[NB-2:0], 1'b0};
                dvs_q[k]  <= dvs_p;
                quo_q[k]  <= {quo_p[NB-2:0], qb};
                side_q[k] <= side_p;
            end
        end
    end

    assign quo_out  = quo_q[NB-1];
    assign side_out = side_q[NB-1];

endmodule

// ----- rtl/rotation_between_two_vectors.sv -----
// rotation_between_two_vectors: rotation matrix turning vector a onto vector b
// depends on rbv_pkg, rbv_sqrt_pipe and rbv_div_pipe
//
// Usage: one input transaction carries a source vector a and a target vector
// b (signed 16-bit components); one output transaction carries the nine
// entries of the rotation matrix in signed Q2.14 and a degenerate code
// (zero-length input, or parallel / antiparallel vectors, give identity).
// Both channels use valid/stall; a transaction completes when valid is high
// and stall is low.
// Throughput: one transaction per clock while in_stall is low. The path from
// the accepting edge, which loads the input register, to output valid runs
// through the 32-stage square root, the 31-stage normalizing divider and the
// 34-stage rounding divider plus nine arithmetic stages and the output
// register.
// Reset clears all valid bits, the output valid included; no clearing pass.
// When the receiver stalls, the finished result holds in the output
// register and the pipeline keeps moving until its last stage is occupied;
// then in_stall rises and every stage holds.

module rotation_between_two_vectors (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [rbv_pkg::IN_W-1:0]  a_x,
    input  logic signed [rbv_pkg::IN_W-1:0]  a_y,
    input  logic signed [rbv_pkg::IN_W-1:0]  a_z,
    input  logic signed [rbv_pkg::IN_W-1:0]  b_x,
    input  logic signed [rbv_pkg::IN_W-1:0]  b_y,
    input  logic signed [rbv_pkg::IN_W-1:0]  b_z,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [15:0]               m00,
    output logic signed [15:0]               m01,
    output logic signed [15:0]               m02,
    output logic signed [15:0]               m10,
    output logic signed [15:0]               m11,
    output logic signed [15:0]               m12,
    output logic signed [15:0]               m20,
    output logic signed [15:0]               m21,
    output logic signed [15:0]               m22,
    output logic [1:0]                       degenerate
);
    import rbv_pkg::*;

    // stage positions
    localparam int unsigned ST_PRE  = 1;
    localparam int unsigned ST_ROOT = ST_PRE + SQRT_STEPS;
    localparam int unsigned ST_UNIT = ST_ROOT + UDIV_STEPS;
    localparam int unsigned ST_M1   = ST_UNIT + 1;
    localparam int unsigned ST_M2   = ST_M1 + 1;
    localparam int unsigned ST_M3   = ST_M2 + 1;
    localparam int unsigned ST_M7   = ST_M3 + 4;
    localparam int unsigned ST_Q    = ST_M7 + QDIV_STEPS;
    localparam int unsigned ST_F1   = ST_Q + 1;
    localparam int unsigned PIPE_N  = ST_F1 + 1;

    localparam int unsigned UNIT_SH = 46 - UDIV_STEPS;
    localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

    // round x / 2^k to nearest, ties away from zero
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                       input int unsigned k);
        logic [63:0] m;
        m = x[63] ? $unsigned(-x) : $unsigned(x);
        m = (m + (64'd1 << (k - 1))) >> k;
        return x[63] ? -$signed(m) : $signed(m);
    endfunction

    logic [PIPE_N-1:0] vld_reg;
    logic              pipe_en;
    logic              out_load;
    logic              out_valid_reg;
    deg_t              code_reg [ST_PRE:PIPE_N-1];

    // pipeline moves while its last stage is empty or the output can take it
    assign out_load = !out_valid_reg || !out_stall;
    assign pipe_en  = !vld_reg[PIPE_N-1] || out_load;
    assign in_stall = !pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[PIPE_N-2:0], in_valid};
        end
    end

    // input register
    logic signed [IN_W-1:0] a_reg [3];
    logic signed [IN_W-1:0] b_reg [3];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_reg[0] <= a_x;
            a_reg[1] <= a_y;
            a_reg[2] <= a_z;
            b_reg[0] <= b_x;
            b_reg[1] <= b_y;
            b_reg[2] <= b_z;
        end
    end

    // squared lengths, exact cross product check, magnitudes
    logic signed [31:0] sq_a [3];
    logic signed [31:0] sq_b [3];
    logic signed [31:0] pab  [3][3];
    logic [31:0]        sa_c;
    logic [31:0]        sb_c;
    logic               par_c;
    deg_t               code_pre;
    logic [5:0][15:0]   mag_c;
    logic [5:0]         sgn_c;

    for (genvar i = 0; i < 3; i++) begin : g_pre
        assign sq_a[i]      = a_reg[i] * a_reg[i];
        assign sq_b[i]      = b_reg[i] * b_reg[i];
        assign mag_c[i]     = a_reg[i][IN_W-1] ? $unsigned(-a_reg[i]) : $unsigned(a_reg[i]);
        assign mag_c[i+3]   = b_reg[i][IN_W-1] ? $unsigned(-b_reg[i]) : $unsigned(b_reg[i]);
        assign sgn_c[i]     = a_reg[i][IN_W-1];
        assign sgn_c[i+3]   = b_reg[i][IN_W-1];
        for (genvar j = 0; j < 3; j++) begin : g_pab
            assign pab[i][j] = a_reg[i] * b_reg[j];
        end
    end

    always_comb
    begin
        sa_c  = $unsigned(sq_a[0]) + $unsigned(sq_a[1]) + $unsigned(sq_a[2]);
        sb_c  = $unsigned(sq_b[0]) + $unsigned(sq_b[1]) + $unsigned(sq_b[2]);
        par_c = (pab[1][2] == pab[2][1]) && (pab[2][0] == pab[0][2])
             && (pab[0][1] == pab[1][0]);
        if (sa_c == 32'd0 || sb_c == 32'd0)
        begin
            code_pre = DEG_ZERO;
        end
        else if (par_c)
        begin
            code_pre = DEG_PAR;
        end
        else
        begin
            code_pre = DEG_NONE;
        end
    end

    logic [31:0]      sa_reg;
    logic [31:0]      sb_reg;
    logic [5:0][15:0] mag_reg;
    logic [5:0]       sgn_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sa_reg  <= sa_c;
            sb_reg  <= sb_c;
            mag_reg <= mag_c;
            sgn_reg <= sgn_c;
        end
    end

    // norms in Q.16
    logic [ROOT_W-1:0] root_a;
    logic [ROOT_W-1:0] root_b;
    logic [5:0][15:0]  mag_s;
    logic [5:0]        sgn_s;

    rbv_sqrt_pipe #(.SW(51)) u_sqrt_a (
        .clk      (clk),
        .en       (pipe_en),
        .s_in     (sa_reg),
        .side_in  ({sgn_reg[2:0], mag_reg[2:0]}),
        .root_out (root_a),
        .side_out ({sgn_s[2:0], mag_s[2:0]})
    );

    rbv_sqrt_pipe #(.SW(51)) u_sqrt_b (
        .clk      (clk),
        .en       (pipe_en),
        .s_in     (sb_reg),
        .side_in  ({sgn_reg[5:3], mag_reg[5:3]}),
        .root_out (root_b),
        .side_out ({sgn_s[5:3], mag_s[5:3]})
    );

    // unit components: mag * 2^46 / norm
    logic [5:0][UDIV_STEPS-1:0] uq;
    logic [5:0]                 usg;

    for (genvar l = 0; l < 6; l++) begin : g_udiv
        rbv_div_pipe #(.NB(UDIV_STEPS), .RW(ROOT_W), .SW(1)) u_udiv (
            .clk      (clk),
            .en       (pipe_en),
            .rem_in   (ROOT_W'({mag_s[l], UNIT_SH'(0)})),
            .low_in   ('0),
            .dvs_in   ((l < 3) ? root_a : root_b),
            .side_in  (sgn_s[l]),
            .quo_out  (uq[l]),
            .side_out (usg[l])
        );
    end

    // signed unit vectors and the nine products of an a component with a b component
    logic signed [31:0] u_s      [6];
    logic signed [63:0] prod_c   [3][3];
    logic signed [63:0] prod_reg [3][3];

    for (genvar l = 0; l < 6; l++) begin : g_usgn
        assign u_s[l] = usg[l] ? -$signed({1'b0, uq[l]}) : $signed({1'b0, uq[l]});
    end

    for (genvar i = 0; i < 3; i++) begin : g_pi
        for (genvar j = 0; j < 3; j++) begin : g_pj
            assign prod_c[i][j] = u_s[i] * u_s[j+3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            prod_reg <= prod_c;
        end
    end

    // cross and dot sums in Q.60
    logic signed [63:0] x_reg [3];
    logic signed [63:0] dot_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            x_reg[0] <= prod_reg[1][2] - prod_reg[2][1];
            x_reg[1] <= prod_reg[2][0] - prod_reg[0][2];
            x_reg[2] <= prod_reg[0][1] - prod_reg[1][0];
            dot_reg  <= prod_reg[0][0] + prod_reg[1][1] + prod_reg[2][2];
        end
    end

    // round to Q1.30, denominator 1 + c
    logic signed [63:0] c_c;
    logic signed [32:0] den_s;
    logic               den_bad;
    deg_t               code_m3;
    logic signed [31:0] v_reg [3];
    logic [31:0]        den3_reg;

    always_comb
    begin
        c_c     = round_shift(dot_reg, 30);
        den_s   = 33'(c_c) + ONE_Q30;
        den_bad = den_s <= 33'sd0;
        code_m3 = (code_reg[ST_M2] == DEG_NONE && den_bad) ? DEG_PAR : code_reg[ST_M2];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v_reg[i] <= 32'(round_shift(x_reg[i], 30));
            end
            den3_reg <= den_s[31:0];
        end
    end

    // v products, identity plus skew part
    logic signed [63:0] vsq_reg  [3];
    logic signed [63:0] vcr_reg  [3];
    logic signed [32:0] base4_reg [9];
    logic [31:0]        den4_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vsq_reg[i] <= v_reg[i] * v_reg[i];
            end
            vcr_reg[0]   <= v_reg[0] * v_reg[1];
            vcr_reg[1]   <= v_reg[0] * v_reg[2];
            vcr_reg[2]   <= v_reg[1] * v_reg[2];
            base4_reg[0] <= ONE_Q30;
            base4_reg[1] <= -33'(v_reg[2]);
            base4_reg[2] <= 33'(v_reg[1]);
            base4_reg[3] <= 33'(v_reg[2]);
            base4_reg[4] <= ONE_Q30;
            base4_reg[5] <= -33'(v_reg[0]);
            base4_reg[6] <= -33'(v_reg[1]);
            base4_reg[7] <= 33'(v_reg[0]);
            base4_reg[8] <= ONE_Q30;
            den4_reg     <= den3_reg;
        end
    end

    // numerators of the square term
    logic signed [63:0] num_reg   [9];
    logic signed [32:0] base5_reg [9];
    logic [31:0]        den5_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            num_reg[0] <= -(vsq_reg[1] + vsq_reg[2]);
            num_reg[4] <= -(vsq_reg[0] + vsq_reg[2]);
            num_reg[8] <= -(vsq_reg[0] + vsq_reg[1]);
            num_reg[1] <= vcr_reg[0];
            num_reg[3] <= vcr_reg[0];
            num_reg[2] <= vcr_reg[1];
            num_reg[6] <= vcr_reg[1];
            num_reg[5] <= vcr_reg[2];
            num_reg[7] <= vcr_reg[2];
            base5_reg  <= base4_reg;
            den5_reg   <= den4_reg;
        end
    end

    // magnitude and sign of numerators
    logic [63:0]        nmag_reg  [9];
    logic [8:0]         nsg6_reg;
    logic signed [32:0] base6_reg [9];
    logic [31:0]        den6_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                nmag_reg[k] <= num_reg[k][63] ? $unsigned(-num_reg[k]) : $unsigned(num_reg[k]);
                nsg6_reg[k] <= num_reg[k][63];
            end
            base6_reg <= base5_reg;
            den6_reg  <= den5_reg;
        end
    end

    // add half the divisor for rounding
    logic [63:0]        d_reg     [9];
    logic [8:0]         nsg7_reg;
    logic signed [32:0] base7_reg [9];
    logic [31:0]        den7_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                d_reg[k] <= nmag_reg[k] + 64'(den6_reg >> 1);
            end
            nsg7_reg  <= nsg6_reg;
            base7_reg <= base6_reg;
            den7_reg  <= den6_reg;
        end
    end

    // rounded quotient; overflow when it would need more than the divider's bits
    logic [QDIV_STEPS-1:0] q_o  [9];
    logic [34:0]           qs_o [9];

    for (genvar k = 0; k < 9; k++) begin : g_qdiv
        logic ovf;

        assign ovf = 32'(d_reg[k][63:QDIV_STEPS]) >= den7_reg;

        rbv_div_pipe #(.NB(QDIV_STEPS), .RW(32), .SW(35)) u_qdiv (
            .clk      (clk),
            .en       (pipe_en),
            .rem_in   (32'(d_reg[k][63:QDIV_STEPS])),
            .low_in   (d_reg[k][QDIV_STEPS-1:0]),
            .dvs_in   (den7_reg),
            .side_in  ({ovf, nsg7_reg[k], base7_reg[k]}),
            .quo_out  (q_o[k]),
            .side_out (qs_o[k])
        );
    end

    // entry in Q.30
    logic signed [QDIV_STEPS+2:0] e_reg [9];
    logic [8:0]                   ovf_reg;
    logic [8:0]                   esg_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                e_reg[k] <= (QDIV_STEPS+3)'($signed(qs_o[k][32:0]))
                          + (qs_o[k][33] ? -$signed({3'b000, q_o[k]})
                                         : $signed({3'b000, q_o[k]}));
                ovf_reg[k] <= qs_o[k][34];
                esg_reg[k] <= qs_o[k][33];
            end
        end
    end

    // degenerate code travels with the data
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            code_reg[ST_PRE] <= code_pre;
            for (int i = ST_PRE + 1; i < PIPE_N; i++)
            begin
                code_reg[i] <= (i == ST_M3) ? code_m3 : code_reg[i-1];
            end
        end
    end

    // round to Q2.14, saturate, identity for degenerate cases
    logic signed [15:0] m_next [9];
    logic signed [15:0] m_reg  [9];
    deg_t               deg_reg;

    always_comb
    begin
        logic signed [63:0] r;
        for (int k = 0; k < 9; k++)
        begin
            r = round_shift(64'(e_reg[k]), 16);
            if (code_reg[PIPE_N-1] != DEG_NONE)
            begin
                m_next[k] = (k % 4 == 0) ? ONE_Q14 : 16'sd0;
            end
            else if (ovf_reg[k])
            begin
                m_next[k] = esg_reg[k] ? -16'sd32768 : 16'sd32767;
            end
            else if (r > 64'sd32767)
            begin
                m_next[k] = 16'sd32767;
            end
            else if (r < -64'sd32768)
            begin
                m_next[k] = -16'sd32768;
            end
            else
            begin
                m_next[k] = 16'(r);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= vld_reg[PIPE_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_reg   <= m_next;
            deg_reg <= code_reg[PIPE_N-1];
        end
    end

    assign out_valid  = out_valid_reg;
    assign m00        = m_reg[0];
    assign m01        = m_reg[1];
    assign m02        = m_reg[2];
    assign m10        = m_reg[3];
    assign m11        = m_reg[4];
    assign m12        = m_reg[5];
    assign m20        = m_reg[6];
    assign m21        = m_reg[7];
    assign m22        = m_reg[8];
    assign degenerate = deg_reg;

endmodule

// ----- rtl/rbv_checker.sv -----
// rbv_checker: port-level assertions for rotation_between_two_vectors
// depends on rbv_pkg; bound to the top level below

module rbv_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] m00,
    input logic signed [15:0] m01,
    input logic signed [15:0] m11,
    input logic signed [15:0] m22,
    input logic [1:0]         degenerate
);
    import rbv_pkg::*;

    // a stalled output transaction holds its m00 and m01 entries and its code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(m00) && $stable(m01)
                                   && $stable(degenerate))
        else $error("stalled output changed");

    // degenerate cases give the identity (diagonal entries and m01 checked)
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate != DEG_NONE |->
            m00 == ONE_Q14 && m11 == ONE_Q14 && m22 == ONE_Q14 && m01 == 16'sd0)
        else $error("degenerate result is not identity");

    // unused degenerate code never shows
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> degenerate == DEG_NONE || degenerate == DEG_ZERO
                      || degenerate == DEG_PAR)
        else $error("bad degenerate code");

endmodule

bind rotation_between_two_vectors rbv_checker u_rbv_checker (.*);

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for rotation_between_two_vectors
// depends on rbv_pkg and the rotation_between_two_vectors rtl
// queue-fed driver, clocked monitor, bit-exact fixed-point predictor

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rbv_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 250;
    localparam int RANDOM_ITEMS   = 1600;
    localparam longint ONE_Q30    = 64'sd1 << 30;

    typedef struct {
        logic signed [15:0] ax, ay, az, bx, by, bz;
        bit                 drain;
    } vec_pair_t;

    typedef struct {
        logic signed [15:0] m [9];
        deg_t               deg;
    } rot_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic [1:0] degenerate;

    vec_pair_t pending_q[$];
    rot_t      rot_q[$];
    int        errors;
    int        idle_cycles;
    int        in_gap, out_gap;
    bit        burst;

    rotation_between_two_vectors i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22), .degenerate(degenerate)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // integer square root, bit by bit
    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // x / 2^k, nearest, ties away from zero
    function automatic longint rnd_shift(input longint x, input int k);
        longint unsigned mag;
        mag = (x < 0) ? longint'(-x) : x;
        mag = (mag + (64'd1 << (k - 1))) >> k;
        return (x < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // n / d, nearest, ties away from zero
    function automatic longint rnd_div(input longint n, input longint d);
        longint unsigned mag;
        longint unsigned ud;
        mag = (n < 0) ? longint'(-n) : n;
        ud = d;
        mag = (mag + ud / 2) / ud;
        return (n < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // unit vector in Q1.30
    function automatic void to_unit(input longint x [3], input longint unsigned s2,
                                    output longint u [3]);
        longint unsigned n;
        longint unsigned mag;
        longint q;
        n = isqrt(s2 << 32);
        for (int i = 0; i < 3; i++)
        begin
            mag = (x[i] < 0) ? longint'(-x[i]) : x[i];
            q = longint'((mag << 46) / n);
            u[i] = (x[i] < 0) ? -q : q;
        end
    endfunction

    function automatic rot_t identity_rot(input deg_t d);
        rot_t r;
        for (int i = 0; i < 9; i++)
            r.m[i] = (i % 4 == 0) ? ONE_Q14 : 16'sd0;
        r.deg = d;
        return r;
    endfunction

    // expected rotation for one vector pair
    function automatic rot_t rodrigues(input vec_pair_t p);
        longint a [3], b [3], ua [3], ub [3], v [3], sk [3][3];
        longint unsigned sa, sb;
        longint c, den, vv, num, e;
        rot_t r;
        a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
        b[0] = p.bx; b[1] = p.by; b[2] = p.bz;
        sa = 0;
        sb = 0;
        for (int i = 0; i < 3; i++)
        begin
            sa += a[i] * a[i];
            sb += b[i] * b[i];
        end
        if (sa == 0 || sb == 0)
            return identity_rot(DEG_ZERO);
        if (a[1] * b[2] - a[2] * b[1] == 0 && a[2] * b[0] - a[0] * b[2] == 0 &&
            a[0] * b[1] - a[1] * b[0] == 0)
            return identity_rot(DEG_PAR);
        to_unit(a, sa, ua);
        to_unit(b, sb, ub);
        v[0] = rnd_shift(ua[1] * ub[2] - ua[2] * ub[1], 30);
        v[1] = rnd_shift(ua[2] * ub[0] - ua[0] * ub[2], 30);
        v[2] = rnd_shift(ua[0] * ub[1] - ua[1] * ub[0], 30);
        c = rnd_shift(ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2], 30);
        den = ONE_Q30 + c;
        if (den <= 0)
            return identity_rot(DEG_PAR);
        sk[0][0] = 0;     sk[0][1] = -v[2]; sk[0][2] = v[1];
        sk[1][0] = v[2];  sk[1][1] = 0;     sk[1][2] = -v[0];
        sk[2][0] = -v[1]; sk[2][1] = v[0];  sk[2][2] = 0;
        vv = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                num = v[i] * v[j] - ((i == j) ? vv : 0);
                e = ((i == j) ? ONE_Q30 : 0) + sk[i][j] + rnd_div(num, den);
                e = rnd_shift(e, 16);
                if (e > 32767)
                    e = 32767;
                if (e < -32768)
                    e = -32768;
                r.m[i * 3 + j] = e[15:0];
            end
        r.deg = DEG_NONE;
        return r;
    endfunction

    // gap length: mostly short, a few long, none inside a burst
    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic vec_pair_t mk(input int ax, ay, az, bx, by, bz);
        vec_pair_t p;
        p.ax = 16'(ax); p.ay = 16'(ay); p.az = 16'(az);
        p.bx = 16'(bx); p.by = 16'(by); p.bz = 16'(bz);
        p.drain = 1'b0;
        return p;
    endfunction

    function automatic logic signed [15:0] rnd16();
        return 16'($urandom());
    endfunction

    // small-magnitude component
    function automatic logic signed [15:0] rnd_small();
        return 16'($signed($urandom_range(0, 200)) - 100);
    endfunction

    // stimulus: directed then random
    initial
    begin
        vec_pair_t p;
        int k, kind;
        pending_q.push_back(mk(0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(0, 0, 0, 5, -3, 7));
        pending_q.push_back(mk(100, 2, -9, 0, 0, 0));
        pending_q.push_back(mk(32767, 0, 0, 0, 32767, 0));
        pending_q.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767));
        pending_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768));
        pending_q.push_back(mk(32767, 32767, 32767, -32768, 32767, -32768));
        pending_q.push_back(mk(3, 4, 5, 6, 8, 10));
        pending_q.push_back(mk(3, 4, 5, -6, -8, -10));
        pending_q.push_back(mk(1, 0, 0, 1, 0, 0));
        pending_q.push_back(mk(32767, 0, 0, -32767, 1, 0));
        pending_q.push_back(mk(32767, 32767, 0, -32767, -32766, 0));
        pending_q.push_back(mk(32767, 0, 0, -32768, 1, 1));
        pending_q.push_back(mk(1, 0, 0, -32768, 1, 0));
        pending_q.push_back(mk(32767, 1, 0, 32767, 0, 1));
        pending_q.push_back(mk(0, 0, 1, 0, 1, 0));
        pending_q.push_back(mk(-1, -1, -1, 1, -1, 1));
        pending_q.push_back(mk(12345, -23456, 30000, -32768, 17, 4));
        // wait for the pipe to empty before the random part
        p = mk(7, -7, 1, -2, 9, 3);
        p.drain = 1'b1;
        pending_q.push_back(p);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
                p = mk(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
            else if (kind < 65)
                p = mk(rnd_small(), rnd_small(), rnd_small(),
                       rnd_small(), rnd_small(), rnd_small());
            else if (kind < 85)
            begin
                // near parallel or antiparallel: b = k*a plus a small offset
                p = mk(rnd_small(), rnd_small(), rnd_small(), 0, 0, 0);
                k = $signed($urandom_range(0, 600)) - 300;
                p.bx = 16'(p.ax * k + $signed($urandom_range(0, 2)) - 1);
                p.by = 16'(p.ay * k + $signed($urandom_range(0, 2)) - 1);
                p.bz = 16'(p.az * k + $signed($urandom_range(0, 2)) - 1);
            end
            else if (kind < 93)
            begin
                p = mk(rnd16(), rnd16(), rnd16(), 0, 0, 0);
                p.bx = -p.ax;
                p.by = -p.ay;
                p.bz = 16'(-p.az + $signed($urandom_range(0, 2)) - 1);
            end
            else
                p = mk(rnd16() & 16'h8001, 0, rnd16() & 16'h0003,
                       0, rnd16() & 16'h8000, 0);
            p.drain = ($urandom_range(0, 399) == 0);
            pending_q.push_back(p);
        end
    end

    // reset and end of run
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_q.size() == 0 && rst_n);
        while (in_valid || rot_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && rot_q.size() == 0 && !out_valid)
            $display("rotation_between_two_vectors: match");
        else
            $display("rotation_between_two_vectors: mismatch");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            a_x <= '0; a_y <= '0; a_z <= '0;
            b_x <= '0; b_y <= '0; b_z <= '0;
            in_gap <= 0;
            burst <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                rot_q.push_back(rodrigues(mk(a_x, a_y, a_z, b_x, b_y, b_z)));
            if (!in_valid || !in_stall)
            begin
                if ($urandom_range(0, 149) == 0)
                    burst <= ~burst;
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain && rot_q.size() != 0))
                begin
                    a_x <= pending_q[0].ax; a_y <= pending_q[0].ay;
                    a_z <= pending_q[0].az; b_x <= pending_q[0].bx;
                    b_y <= pending_q[0].by; b_z <= pending_q[0].bz;
                    void'(pending_q.pop_front());
                    in_valid <= 1'b1;
                    in_gap <= pick_gap(burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [15:0] got [9];
        rot_t want;
        int bad;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
            errors <= 0;
        end
        else
        begin
            bad = 0;
            if (out_valid && !out_stall)
            begin
                got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
                if (rot_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction, m00=%0d degenerate=%0d",
                             $realtime, m00, degenerate);
                    bad = bad + 1;
                end
                else
                begin
                    want = rot_q.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== want.m[i])
                        begin
                            $display("%0t: m%0d%0d expected %0d actual %0d",
                                     $realtime, i / 3, i % 3, want.m[i], got[i]);
                            bad = bad + 1;
                        end
                    if (degenerate !== want.deg)
                    begin
                        $display("%0t: degenerate expected %0d actual %0d",
                                 $realtime, want.deg, degenerate);
                        bad = bad + 1;
                    end
                end
            end
            if (bad != 0)
                errors <= errors + bad;
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_gap <= pick_gap(burst);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rotation_between_two_vectors: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ----- filelist.f -----
rtl/rbv_pkg.sv
rtl/rbv_sqrt_pipe.sv
rtl/rbv_div_pipe.sv
rtl/rotation_between_two_vectors.sv
rtl/rbv_checker.sv
test/tb_top.sv
